// ===== sv/hcbd_pkg.sv =====
// Shared types, codes and helpers of the HTTP chunked body decoder.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_CR   = 8'h0D;
    localparam t_byte CH_LF   = 8'h0A;
    localparam t_byte CH_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_CR,
        PH_EXT,
        PH_DATA,
        PH_TRAIL_CR,
        PH_TRAIL_LF,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_TRUNCATED
    } t_status;

    // One registered input word.
    typedef struct packed {
        logic  valid;
        t_byte in_byte;
        logic  body_end;
    } t_item;

    // One result word as it leaves the decoder.
    typedef struct packed {
        t_byte   out_byte;
        logic    payload_valid;
        logic    body_done;
        t_status status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Letters in either case share the low nibble pattern, so a+9 gives the value.
    function automatic t_hex hex_digit(input t_byte ch);
        t_hex h;
        h.ok  = 1'b0;
        h.val = ch[3:0];
        if (ch inside {[8'h30:8'h39]}) begin
            h.ok = 1'b1;
        end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.ok  = 1'b1;
            h.val = ch[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// ===== sv/hcbd_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result words.
interface hcbd_in_if;
    import hcbd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  body_end;

    modport source (output valid, output in_byte, output body_end, input ready);
    modport sink   (input valid, input in_byte, input body_end, output ready);
endinterface

interface hcbd_out_if;
    import hcbd_pkg::*;

    logic    valid;
    logic    ready;
    t_byte   out_byte;
    logic    payload_valid;
    logic    body_done;
    t_status status;

    modport source (output valid, output out_byte, output payload_valid,
                    output body_done, output status, input ready);
    modport sink   (input valid, input out_byte, input payload_valid,
                    input body_done, input status, output ready);
endinterface

// ===== sv/hcbd_in_reg.sv =====
// Input register stage: captures an input word per cycle unless stalled.
module hcbd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hcbd_in_if.sink         i_in,
    input  logic            i_advance,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    logic  r_valid;
    t_byte r_byte;
    logic  r_end;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_end  <= i_in.body_end;
        end
    end

    assign o_item.valid    = r_valid;
    assign o_item.in_byte  = r_byte;
    assign o_item.body_end = r_end;
endmodule

// ===== sv/hcbd_step.sv =====
// Next-state and result logic of the chunked body parser for one byte.
module hcbd_step #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  hcbd_pkg::t_phase       i_phase,
    input  logic [SIZE_BITS-1:0]   i_size_accum,
    input  logic                   i_digit_seen,
    input  logic [SIZE_BITS-1:0]   i_bytes_left,
    input  hcbd_pkg::t_byte        i_in_byte,
    input  logic                   i_body_end,
    output hcbd_pkg::t_phase       o_phase,
    output logic [SIZE_BITS-1:0]   o_size_accum,
    output logic                   o_digit_seen,
    output logic [SIZE_BITS-1:0]   o_bytes_left,
    output logic                   o_has_result,
    output hcbd_pkg::t_result      o_result
);
    import hcbd_pkg::*;

    t_hex                 hex;
    logic                 do_size;
    logic                 do_end;
    logic                 pay;
    logic                 done;
    t_status              status;
    logic [SIZE_BITS-1:0] left_dec;

    assign hex      = hex_digit(i_in_byte);
    assign left_dec = (i_bytes_left != '0) ? i_bytes_left - SIZE_BITS'(1) : i_bytes_left;

    always_comb begin
        o_phase      = i_phase;
        o_size_accum = i_size_accum;
        o_digit_seen = i_digit_seen;
        o_bytes_left = i_bytes_left;
        do_size      = 1'b0;
        do_end       = 1'b0;
        pay          = 1'b0;
        done         = 1'b0;
        status       = ST_OK;

        case (i_phase)
            PH_SIZE: begin
                do_size = 1'b1;
            end
            PH_SIZE_CR: begin
                if (i_in_byte == CH_LF) begin
                    do_end = 1'b1;
                end else begin
                    done   = 1'b1;
                    status = ST_MALFORMED;
                end
            end
            PH_EXT: begin
                do_end = (i_in_byte == CH_LF);
            end
            PH_DATA: begin
                pay          = 1'b1;
                o_bytes_left = left_dec;
                if (left_dec == '0) begin
                    o_phase = PH_TRAIL_CR;
                end
            end
            PH_TRAIL_CR: begin
                if (i_in_byte == CH_CR) begin
                    o_phase = PH_TRAIL_LF;
                end else if (i_in_byte == CH_LF) begin
                    o_phase = PH_SIZE;
                end else begin
                    do_size = 1'b1;
                end
            end
            PH_TRAIL_LF: begin
                o_phase = PH_SIZE;
                do_size = (i_in_byte != CH_LF);
            end
            default: begin
            end
        endcase

        // A byte of the size line proper.
        if (do_size) begin
            if (hex.ok) begin
                o_size_accum = {i_size_accum[SIZE_BITS-5:0], hex.val};
                o_digit_seen = 1'b1;
                o_phase      = PH_SIZE;
            end else if (i_in_byte == CH_SEMI) begin
                o_phase = PH_EXT;
            end else if (i_in_byte == CH_CR) begin
                o_phase = PH_SIZE_CR;
            end else if (i_in_byte == CH_LF) begin
                do_end = 1'b1;
            end else begin
                done   = 1'b1;
                status = ST_MALFORMED;
            end
        end

        if (do_end) begin
            if (!i_digit_seen) begin
                done   = 1'b1;
                status = ST_MALFORMED;
            end else if (i_size_accum == '0) begin
                done   = 1'b1;
                status = ST_OK;
            end else begin
                o_bytes_left = i_size_accum;
                o_phase      = PH_DATA;
            end
            o_size_accum = '0;
            o_digit_seen = 1'b0;
        end

        if (done) begin
            o_phase = PH_DONE;
        end

        // The last byte of a body restarts the parser; truncation if undecided.
        if (i_body_end) begin
            if (!done && i_phase != PH_DONE) begin
                done   = 1'b1;
                status = ST_TRUNCATED;
            end
            o_phase      = PH_SIZE;
            o_size_accum = '0;
            o_digit_seen = 1'b0;
            o_bytes_left = '0;
        end

        o_has_result           = pay || done;
        o_result.out_byte      = pay ? i_in_byte : '0;
        o_result.payload_valid = pay;
        o_result.body_done     = done;
        o_result.status        = done ? status : ST_OK;
    end
endmodule

// ===== sv/http_chunked_body_decoder_core.sv =====
// Decodes an HTTP chunked body at one byte per clock. Each accepted word passes an input
// register, then one short step of parse logic updates the size, count and phase registers
// and loads the result register, and a new word is taken every cycle while the result
// side keeps up. A word yields a result only when it carries a payload byte or decides
// the body's outcome; the status is success, malformed size line, or truncated body, and
// the parser is back at the start of a size line after the word flagged as the body's
// end.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);
    import hcbd_pkg::*;

    t_item                r_item;
    logic                 advance;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [SIZE_BITS-1:0] r_size_accum;
    logic [SIZE_BITS-1:0] n_size_accum;
    logic                 r_digit_seen;
    logic                 n_digit_seen;
    logic [SIZE_BITS-1:0] r_bytes_left;
    logic [SIZE_BITS-1:0] n_bytes_left;

    logic                 has_result;
    t_result              step_result;
    logic                 r_out_valid;
    t_result              r_out;

    assign advance = r_item.valid && (!r_out_valid || o_out.ready);

    hcbd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_item    (r_item)
    );

    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_phase      (r_phase),
        .i_size_accum (r_size_accum),
        .i_digit_seen (r_digit_seen),
        .i_bytes_left (r_bytes_left),
        .i_in_byte    (r_item.in_byte),
        .i_body_end   (r_item.body_end),
        .o_phase      (n_phase),
        .o_size_accum (n_size_accum),
        .o_digit_seen (n_digit_seen),
        .o_bytes_left (n_bytes_left),
        .o_has_result (has_result),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_size_accum <= '0;
            r_digit_seen <= 1'b0;
            r_bytes_left <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_size_accum <= n_size_accum;
            r_digit_seen <= n_digit_seen;
            r_bytes_left <= n_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.body_done     = r_out.body_done;
    assign o_out.status        = r_out.status;

    a_result_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.payload_valid || r_out.body_done))
        else $error("result word carries neither payload nor outcome");

    a_status_only_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.body_done) |-> (r_out.status == ST_OK))
        else $error("nonzero status without body_done");

    a_data_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with no bytes left");

    a_body_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_item.body_end) |=>
            (r_phase == PH_SIZE && !r_digit_seen && r_size_accum == '0))
        else $error("parser not back at size line after body end");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP chunked body decoder core.
module tb;
    import hcbd_pkg::*;

    localparam int SZ = SIZE_BITS_DEF;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_body_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_body_byte  pending_words[$];
    t_byte       draft[$];
    t_result     expected_out[$];
    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned stall_left   = 0;
    logic        stall_used   = 1'b0;

    // Decoder state as the checker tracks it.
    t_phase         dec_phase;
    logic [SZ-1:0]  dec_size;
    logic [SZ-1:0]  dec_remaining;
    logic           dec_digits;
    logic           dec_outcome;
    logic           dec_done;
    t_status        dec_status;

    // Queue appends.
    function automatic void draft_add(input t_byte b);
        draft.insert(draft.size(), b);
    endfunction

    function automatic void pending_add(input t_body_byte w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void expect_add(input t_result r);
        expected_out.insert(expected_out.size(), r);
    endfunction

    function automatic void dec_clear();
        dec_phase     = PH_SIZE;
        dec_size      = '0;
        dec_digits    = 1'b0;
        dec_remaining = '0;
        dec_outcome   = 1'b0;
    endfunction

    function automatic void settle(input t_status st);
        dec_done    = 1'b1;
        dec_status  = st;
        dec_outcome = 1'b1;
        dec_phase   = PH_DONE;
    endfunction

    function automatic void finish_size_line();
        if (!dec_digits) begin
            settle(ST_MALFORMED);
        end else if (dec_size == '0) begin
            settle(ST_OK);
        end else begin
            dec_remaining = dec_size;
            dec_phase     = PH_DATA;
        end
        dec_size   = '0;
        dec_digits = 1'b0;
    endfunction

    function automatic void size_char(input t_byte ch);
        logic [3:0] nib;
        logic       is_hex;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            nib = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            nib = 4'(ch - 8'h61 + 8'd10);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            nib = 4'(ch - 8'h41 + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        if (is_hex) begin
            // The size wraps at its width, so the top digit simply falls off.
            dec_size   = {dec_size[SZ-5:0], nib};
            dec_digits = 1'b1;
            dec_phase  = PH_SIZE;
        end else if (ch == CH_SEMI) begin
            dec_phase = PH_EXT;
        end else if (ch == CH_CR) begin
            dec_phase = PH_SIZE_CR;
        end else if (ch == CH_LF) begin
            finish_size_line();
        end else begin
            settle(ST_MALFORMED);
        end
    endfunction

    function automatic void predict_word(input t_byte ch, input logic last);
        t_result r;
        logic    pay;
        pay        = 1'b0;
        dec_done   = 1'b0;
        dec_status = ST_OK;
        case (dec_phase)
            PH_SIZE: size_char(ch);
            PH_SIZE_CR: begin
                if (ch == CH_LF) finish_size_line();
                else settle(ST_MALFORMED);
            end
            PH_EXT: begin
                if (ch == CH_LF) finish_size_line();
            end
            PH_DATA: begin
                pay = 1'b1;
                if (dec_remaining != '0) dec_remaining = dec_remaining - SZ'(1);
                if (dec_remaining == '0) dec_phase = PH_TRAIL_CR;
            end
            PH_TRAIL_CR: begin
                if (ch == CH_CR) begin
                    dec_phase = PH_TRAIL_LF;
                end else if (ch == CH_LF) begin
                    dec_phase = PH_SIZE;
                end else begin
                    dec_phase = PH_SIZE;
                    size_char(ch);
                end
            end
            PH_TRAIL_LF: begin
                dec_phase = PH_SIZE;
                if (ch != CH_LF) size_char(ch);
            end
            default: ;
        endcase
        if (last) begin
            if (!dec_outcome) begin
                dec_done   = 1'b1;
                dec_status = ST_TRUNCATED;
            end
            dec_clear();
        end
        if (pay || dec_done) begin
            r.out_byte      = pay ? ch : 8'h00;
            r.payload_valid = pay;
            r.body_done     = dec_done;
            r.status        = dec_status;
            expect_add(r);
        end
    endfunction

    // Stimulus construction: bytes gather in the draft, then go out as one body.
    function automatic void commit_draft();
        t_body_byte w;
        for (int i = 0; i < draft.size(); i++) begin
            w.data = draft[i];
            w.last = (i == draft.size() - 1);
            pending_add(w);
            words_queued++;
        end
        draft.delete();
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) draft_add(t_byte'(s[i]));
    endfunction

    function automatic t_byte hex_char(input logic [3:0] n);
        t_byte letter_base;
        letter_base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
        if (n < 4'd10) return 8'h30 + 8'(n);
        return letter_base + 8'(n) - 8'd10;
    endfunction

    function automatic t_byte noise_byte();
        case ($urandom_range(0, 4))
            0: return hex_char(4'($urandom_range(0, 15)));
            1: return CH_CR;
            2: return CH_LF;
            3: return CH_SEMI;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void put_size_line(input logic [SZ-1:0] v);
        int    nd;
        int    pad;
        t_byte b;
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
        if ($urandom_range(0, 15) == 0) begin
            // Overlong line: the leading digits are shifted out past the size width.
            repeat ($urandom_range(1, 2)) draft_add(hex_char(4'($urandom_range(1, 15))));
            nd = 8;
        end else begin
            pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
            repeat (pad) draft_add(8'h30);
        end
        for (int i = nd - 1; i >= 0; i--) draft_add(hex_char(v[4*i +: 4]));
        if ($urandom_range(0, 3) == 0) begin
            draft_add(CH_SEMI);
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom_range(0, 255));
                draft_add((b == CH_LF) ? CH_SEMI : b);
            end
        end
        if ($urandom_range(0, 2) != 0) draft_add(CH_CR);
        draft_add(CH_LF);
    endfunction

    function automatic void put_chunked_body();
        int unsigned n;
        int unsigned k;
        repeat ($urandom_range(0, 4)) begin
            k = $urandom_range(0, 39);
            if (k == 0) n = $urandom_range(65, 300);
            else if (k < 5) n = $urandom_range(17, 64);
            else n = $urandom_range(1, 16);
            put_size_line(SZ'(n));
            repeat (n) draft_add(8'($urandom_range(0, 255)));
            k = $urandom_range(0, 9);
            if (k < 6) begin
                draft_add(CH_CR);
                draft_add(CH_LF);
            end else if (k < 8) begin
                draft_add(CH_LF);
            end else if (k == 8) begin
                draft_add(CH_CR);
            end
        end
        put_size_line('0);
        // Bytes after the closing line are ignored by the decoder.
        repeat ($urandom_range(0, 3)) draft_add(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_random_bodies(input int unsigned target);
        int unsigned start;
        int unsigned cut;
        int unsigned k;
        start = words_queued;
        while (words_queued - start < target) begin
            k = $urandom_range(0, 19);
            if (k < 17) begin
                put_chunked_body();
                if (k >= 13 && k < 15 && draft.size() > 1) begin
                    cut = $urandom_range(1, draft.size() - 1);
                    while (draft.size() > cut) draft.delete(draft.size() - 1);
                end else if (k >= 15) begin
                    draft[$urandom_range(0, draft.size() - 1)] = noise_byte();
                end
            end else begin
                repeat ($urandom_range(1, 8)) draft_add(noise_byte());
            end
            commit_draft();
        end
    endfunction

    task automatic wait_drained();
        while (words_taken != words_queued || expected_out.size() != 0) @(posedge i_clk);
    endtask

    // Input driver: a word stays offered until it is taken.
    always @(posedge i_clk) begin
        t_body_byte w;
        if (!i_rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.in_byte  <= 8'h00;
            in_ch.body_end <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.in_byte, in_ch.body_end);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() != 0 &&
                    ((words_taken >= 700 && words_taken < 950) ||
                     $urandom_range(0, 99) >= 37)) begin
                    w = pending_words.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.in_byte  <= w.data;
                    in_ch.body_end <= w.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready generator.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                got.out_byte      = out_ch.out_byte;
                got.payload_valid = out_ch.payload_valid;
                got.body_done     = out_ch.body_done;
                got.status        = out_ch.status;
                if (expected_out.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: byte %02h pay %b done %b status %0d",
                             $time, got.out_byte, got.payload_valid, got.body_done,
                             got.status);
                end else begin
                    want = expected_out.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch: expected byte %02h pay %b done %b status %0d,",
                                 $time, want.out_byte, want.payload_valid, want.body_done,
                                 want.status);
                        $display("    actual byte %02h pay %b done %b status %0d",
                                 got.out_byte, got.payload_valid, got.body_done, got.status);
                    end
                end
            end
            // One long hold-off lets the decoder fill up and push back on its input.
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!stall_used && results_seen >= 400) begin
                stall_used = 1'b1;
                stall_left = 160;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (results_seen >= 500 && results_seen < 700) ||
                                $urandom_range(0, 99) >= 37;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        dec_clear();

        // Two data bytes at the byte extremes, an extension, no trailer before the last line.
        put_text("2;e");
        draft_add(CH_LF);
        draft_add(8'h00);
        draft_add(8'hFF);
        put_text("0");
        draft_add(CH_LF);
        commit_draft();
        // A line with no digits at all.
        draft_add(CH_LF);
        commit_draft();
        // A non-hex byte, then a byte that is ignored after the outcome.
        put_text("gx");
        commit_draft();
        // A carriage return among the digits without a line feed after it.
        put_text("1");
        draft_add(CH_CR);
        put_text("x");
        commit_draft();
        // Body ends inside a size line.
        put_text("A");
        commit_draft();
        // Nine digits wrap to a zero size.
        put_text("100000000");
        draft_add(CH_LF);
        commit_draft();
        // Body ends on the last data byte.
        put_text("1");
        draft_add(CH_LF);
        put_text("Q");
        commit_draft();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        queue_random_bodies(450);
        // The sender pauses here until every result so far has come back.
        wait_drained();
        queue_random_bodies(850);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_out.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hcbd_pkg.sv
sv/hcbd_if.sv
sv/hcbd_in_reg.sv
sv/hcbd_step.sv
sv/http_chunked_body_decoder_core.sv
tb/sv/tb.sv
